// ----- src/pbts_pkg.sv -----
// Package with shared types, operation codes and a helper for the task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pbts_pkg;

  // Width of a task index and of the enable mask.
  localparam int TASK_W            = 5;
  localparam int MASK_W            = 32;
  localparam int DELAY_W           = 32;
  localparam int LOCK_W            = 8;
  localparam int NUM_TASKS_DEFAULT = 32;

  localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

  // Operation codes carried in the func field.
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_DELAY  = 3'd1;
  localparam logic [2:0] FUNC_LOCK   = 3'd2;
  localparam logic [2:0] FUNC_UNLOCK = 3'd3;
  localparam logic [2:0] FUNC_START  = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic [DELAY_W-1:0] delay_ticks;
  } sched_in_t;

  typedef struct packed {
    logic              switch_now;
    logic [TASK_W-1:0] next_task;
    logic [LOCK_W-1:0] lock_depth;
    logic              sched_blocked;
    logic              none_ready;
  } sched_out_t;

  typedef struct packed {
    logic              found;
    logic [TASK_W-1:0] idx;
  } pick_t;

  // Lowest set bit of a candidate vector, with a flag for an empty vector.
  function automatic pick_t pick_first(input logic [MASK_W-1:0] cand);
    pick_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.found = 1'b1;
        res.idx   = TASK_W'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/pbts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pbts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/priority_bitmap_task_scheduler.sv -----
// Top level of the priority bitmap task scheduler with tick delays.
`timescale 1ns / 1ps
`default_nettype none

// Task scheduler for up to 32 priority-numbered tasks (index 0 is the highest
// priority). Each input transaction carries one operation and yields exactly
// one result transaction. The block works on one operation at a time and
// raises in_ready only while idle. A tick walks every delay counter through a
// single shared decrementer, one counter per cycle out of a RAM with
// registered read, and then schedules; delay and an unlock that reaches zero
// pass through the scheduling step, start through the start step, and lock and
// other operations go straight to the result. The block is ready again in the cycle
// after its result is registered. A result waiting in the output register
// stalls only the final step of the following operation. The enable mask must
// only be written while the block is idle.
module priority_bitmap_task_scheduler #(
  parameter int NUM_TASKS = pbts_pkg::NUM_TASKS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pbts_pkg::MASK_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire pbts_pkg::sched_in_t           in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pbts_pkg::sched_out_t               out_data
);

  localparam int EFF_TASKS = (NUM_TASKS < pbts_pkg::MASK_W) ? NUM_TASKS : pbts_pkg::MASK_W;
  localparam int IDX_W     = $clog2(EFF_TASKS);
  localparam int CNT_W     = IDX_W + 1;
  localparam logic [pbts_pkg::MASK_W-1:0] TASK_RANGE =
    pbts_pkg::MASK_W'((64'(1) << EFF_TASKS) - 64'(1));

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_SCHED = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                       state;
  logic [pbts_pkg::MASK_W-1:0]      enable_mask;
  logic [pbts_pkg::MASK_W-1:0]      ready_bits;
  logic [EFF_TASKS-1:0]             delay_valid;
  logic [pbts_pkg::TASK_W-1:0]      running_task;
  logic                             started;
  logic [pbts_pkg::LOCK_W-1:0]      lock_count;
  logic [CNT_W-1:0]                 cnt;
  logic                             sw_flag;
  logic                             blocked_flag;
  logic                             none_flag;

  logic                             accept;
  logic [IDX_W-1:0]                 proc_idx;
  logic [pbts_pkg::DELAY_W-1:0]     rd_data;
  logic [pbts_pkg::DELAY_W-1:0]     cur_delay;
  logic                             proc_active;
  logic                             proc_enabled;
  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  logic [pbts_pkg::DELAY_W-1:0]     ram_wdata;
  pbts_pkg::pick_t                  pick;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Delay counter under work in the tick walk; its read was issued in the previous cycle.
  assign proc_idx     = IDX_W'(cnt - CNT_W'(1));
  assign proc_active  = (state == S_TICK) && (cnt != '0);
  assign cur_delay    = delay_valid[proc_idx] ? rd_data : '0;
  assign proc_enabled = enable_mask[pbts_pkg::TASK_W'(proc_idx)];

  // Lowest enabled ready task within the populated range.
  assign pick = pbts_pkg::pick_first(ready_bits & enable_mask & TASK_RANGE);

  // Delay RAM write port: the decrementer during a tick, the load for a delay.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_idx;
    ram_wdata = cur_delay - pbts_pkg::DELAY_W'(1);
    if (accept && in_data.func == pbts_pkg::FUNC_DELAY) begin
      ram_we    = 1'b1;
      ram_waddr = running_task[IDX_W-1:0];
      ram_wdata = in_data.delay_ticks;
    end else if (proc_active && proc_enabled && cur_delay != '0) begin
      ram_we = 1'b1;
    end
  end

  pbts_ram #(
    .WIDTH (pbts_pkg::DELAY_W),
    .DEPTH (EFF_TASKS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Sequencer and scheduler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enable_mask  <= '0;
      ready_bits   <= '1;
      delay_valid  <= '0;
      running_task <= '0;
      started      <= 1'b0;
      lock_count   <= '0;
      cnt          <= '0;
      sw_flag      <= 1'b0;
      blocked_flag <= 1'b0;
      none_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable_mask <= cfg_wr_data;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        delay_valid[ram_waddr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            sw_flag      <= 1'b0;
            blocked_flag <= 1'b0;
            none_flag    <= 1'b0;
            cnt          <= '0;
            case (in_data.func)
              pbts_pkg::FUNC_TICK: begin
                state <= S_TICK;
              end
              pbts_pkg::FUNC_DELAY: begin
                ready_bits[running_task] <= 1'b0;
                state                    <= S_SCHED;
              end
              pbts_pkg::FUNC_LOCK: begin
                if (lock_count != pbts_pkg::LOCK_MAX) begin
                  lock_count <= lock_count + pbts_pkg::LOCK_W'(1);
                end
                state <= S_DONE;
              end
              pbts_pkg::FUNC_UNLOCK: begin
                if (lock_count != '0) begin
                  lock_count <= lock_count - pbts_pkg::LOCK_W'(1);
                end
                if (lock_count == pbts_pkg::LOCK_W'(1)) begin
                  state <= S_SCHED;
                end else begin
                  state <= S_DONE;
                end
              end
              pbts_pkg::FUNC_START: begin
                state <= S_START;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        // Walk the delay counters; a zero delay on an enabled task makes it ready.
        S_TICK: begin
          if (proc_active && proc_enabled && cur_delay == '0) begin
            ready_bits[pbts_pkg::TASK_W'(proc_idx)] <= 1'b1;
          end
          if (cnt == CNT_W'(EFF_TASKS)) begin
            state <= S_SCHED;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end

        // Schedule: skipped before start, blocked while locked.
        S_SCHED: begin
          if (started) begin
            if (lock_count != '0) begin
              blocked_flag <= 1'b1;
            end else if (!pick.found) begin
              none_flag <= 1'b1;
            end else if (pick.idx != running_task) begin
              running_task <= pick.idx;
              sw_flag      <= 1'b1;
            end
          end
          state <= S_DONE;
        end

        // Start ignores the lock; on the first start it reports a switch unless no task is ready.
        S_START: begin
          if (!pick.found) begin
            none_flag <= 1'b1;
          end else begin
            sw_flag      <= !started || (pick.idx != running_task);
            running_task <= pick.idx;
          end
          started <= 1'b1;
          state   <= S_DONE;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.switch_now    <= sw_flag;
            out_data.next_task     <= running_task;
            out_data.lock_depth    <= lock_count;
            out_data.sched_blocked <= blocked_flag;
            out_data.none_ready    <= none_flag;
            state                  <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_priority_bitmap_task_scheduler.sv -----
// Self-checking testbench for the priority bitmap task scheduler.
`timescale 1ns / 1ps

// Tracks the scheduler state and holds the results that accepted operations should produce.
class task_sched_tracker;
  logic [pbts_pkg::MASK_W-1:0]  enable_mask;
  logic [pbts_pkg::MASK_W-1:0]  ready_bits;
  logic [pbts_pkg::DELAY_W-1:0] delay_left [32];
  logic [pbts_pkg::TASK_W-1:0]  running;
  bit                           started;
  logic [pbts_pkg::LOCK_W-1:0]  lock_depth;
  pbts_pkg::sched_out_t         expected_results [$];
  int                           errors;
  int                           checked;
  int                           report_limit;
  int                           op_count [8];
  int                           n_switch;
  int                           n_blocked;
  int                           n_none;
  int                           n_saturated;

  function new();
    enable_mask  = '0;
    ready_bits   = '1;
    running      = '0;
    started      = 1'b0;
    lock_depth   = '0;
    errors       = 0;
    checked      = 0;
    report_limit = 200;
    n_switch     = 0;
    n_blocked    = 0;
    n_none       = 0;
    n_saturated  = 0;
    for (int i = 0; i < 32; i++) begin
      delay_left[i] = '0;
      op_count[i % 8] = 0;
    end
  endfunction

  // Lowest index that is both enabled and ready, or -1 when none is.
  function int first_ready();
    logic [pbts_pkg::MASK_W-1:0] cand;
    cand = ready_bits & enable_mask;
    for (int i = 0; i < 32; i++) begin
      if (cand[i]) return i;
    end
    return -1;
  endfunction

  // A schedule is skipped before start and held off while locked.
  function void schedule_into(inout pbts_pkg::sched_out_t res);
    int t;
    if (!started) return;
    if (lock_depth != '0) begin
      res.sched_blocked = 1'b1;
      return;
    end
    t = first_ready();
    if (t < 0) begin
      res.none_ready = 1'b1;
      return;
    end
    if (t != running) begin
      running        = pbts_pkg::TASK_W'(t);
      res.switch_now = 1'b1;
    end
  endfunction

  // Applies one accepted input transaction and queues the result it causes.
  function void note_operation(pbts_pkg::sched_in_t op);
    pbts_pkg::sched_out_t res;
    int                   t;
    res = '0;
    op_count[op.func]++;
    case (op.func)
      pbts_pkg::FUNC_TICK: begin
        for (int i = 0; i < 32; i++) begin
          if (enable_mask[i]) begin
            if (delay_left[i] != '0) delay_left[i] = delay_left[i] - 1'b1;
            else ready_bits[i] = 1'b1;
          end
        end
        schedule_into(res);
      end
      pbts_pkg::FUNC_DELAY: begin
        delay_left[running] = op.delay_ticks;
        ready_bits[running] = 1'b0;
        schedule_into(res);
      end
      pbts_pkg::FUNC_LOCK: begin
        if (lock_depth != pbts_pkg::LOCK_MAX) lock_depth = lock_depth + 1'b1;
        else n_saturated++;
      end
      pbts_pkg::FUNC_UNLOCK: begin
        if (lock_depth != '0) begin
          lock_depth = lock_depth - 1'b1;
          if (lock_depth == '0) schedule_into(res);
        end
      end
      pbts_pkg::FUNC_START: begin
        t = first_ready();
        if (t < 0) begin
          res.none_ready = 1'b1;
        end else begin
          if (!started || t != running) res.switch_now = 1'b1;
          running = pbts_pkg::TASK_W'(t);
        end
        started = 1'b1;
      end
      default: begin
      end
    endcase
    res.next_task  = running;
    res.lock_depth = lock_depth;
    n_switch  += int'(res.switch_now);
    n_blocked += int'(res.sched_blocked);
    n_none    += int'(res.none_ready);
    expected_results.push_back(res);
  endfunction

  function void report_field(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= report_limit)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  // Compares one accepted result transaction with the oldest expectation.
  function void check_result(pbts_pkg::sched_out_t got);
    pbts_pkg::sched_out_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result with no expectation waiting, actual %h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    checked++;
    if (got.switch_now !== want.switch_now)
      report_field("switch_now", 32'(want.switch_now), 32'(got.switch_now));
    if (got.next_task !== want.next_task)
      report_field("next_task", 32'(want.next_task), 32'(got.next_task));
    if (got.lock_depth !== want.lock_depth)
      report_field("lock_depth", 32'(want.lock_depth), 32'(got.lock_depth));
    if (got.sched_blocked !== want.sched_blocked)
      report_field("sched_blocked", 32'(want.sched_blocked), 32'(got.sched_blocked));
    if (got.none_ready !== want.none_ready)
      report_field("none_ready", 32'(want.none_ready), 32'(got.none_ready));
  endfunction
endclass

module tb_priority_bitmap_task_scheduler;

  // A tick walks all counters, so this covers the longest operation plus margin.
  localparam int         SETTLE_CYCLES   = 40;
  localparam int         CYCLE_LIMIT     = 800_000;
  localparam int         RANDOM_PER_MASK = 180;
  localparam logic [2:0] FUNC_UNUSED_LO  = pbts_pkg::FUNC_START + 3'd1;
  localparam logic [2:0] FUNC_UNUSED_HI  = 3'd7;

  logic                        clk;
  logic                        rst         = 1'b1;
  logic                        cfg_wr_en   = 1'b0;
  logic [pbts_pkg::MASK_W-1:0] cfg_wr_data = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  pbts_pkg::sched_in_t         in_data     = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  pbts_pkg::sched_out_t        out_data;

  task_sched_tracker tracker;
  int                burst_left    = 0;
  int                ops_sent      = 0;
  int                masks_written = 0;
  int                cycle_count   = 0;
  int                stall_mode    = 0;
  int                mode_left     = 0;

  priority_bitmap_task_scheduler DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
               tracker.expected_results.size());
      $display("** priority_bitmap_task_scheduler: FAILED **");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick the next stall pattern.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(out_data);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left = mode_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycle_count % 7) < 3;
    endcase
  end

  function automatic pbts_pkg::sched_in_t make_op(logic [2:0] func,
                                                  logic [pbts_pkg::DELAY_W-1:0] dly);
    pbts_pkg::sched_in_t op;
    op.func        = func;
    op.delay_ticks = dly;
    return op;
  endfunction

  // Mostly short delays so that tasks come back; now and then one that never expires.
  function automatic logic [pbts_pkg::DELAY_W-1:0] random_delay();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 6);
    if (roll < 98) return $urandom_range(7, 60);
    return $urandom;
  endfunction

  function automatic pbts_pkg::sched_in_t random_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 38) return make_op(pbts_pkg::FUNC_TICK, $urandom);
    if (roll < 63) return make_op(pbts_pkg::FUNC_DELAY, random_delay());
    if (roll < 76) return make_op(pbts_pkg::FUNC_LOCK, $urandom);
    if (roll < 91) return make_op(pbts_pkg::FUNC_UNLOCK, $urandom);
    if (roll < 96) return make_op(pbts_pkg::FUNC_START, $urandom);
    return make_op(3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)), $urandom);
  endfunction

  // Sends one input transaction; the sender works in bursts separated by gaps.
  task automatic send_op(input pbts_pkg::sched_in_t op);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    tracker.note_operation(op);
    burst_left--;
    ops_sent++;
  endtask

  // Holds the sender until every expected result has arrived and the block is idle.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable_mask(input logic [pbts_pkg::MASK_W-1:0] mask);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.enable_mask = mask;
    masks_written++;
  endtask

  // Random phase: single operations, balanced lock nests and runs of ticks.
  task automatic run_random(input int count);
    int target;
    int nest;
    target = ops_sent + count;
    while (ops_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          nest = $urandom_range(1, 4);
          repeat (nest) send_op(make_op(pbts_pkg::FUNC_LOCK, $urandom));
          repeat ($urandom_range(1, 4))
            send_op(make_op($urandom_range(0, 1) ? pbts_pkg::FUNC_TICK
                                                 : pbts_pkg::FUNC_DELAY,
                            random_delay()));
          repeat (nest) send_op(make_op(pbts_pkg::FUNC_UNLOCK, $urandom));
        end
        2: repeat ($urandom_range(2, 8)) send_op(make_op(pbts_pkg::FUNC_TICK, $urandom));
        default: send_op(random_op());
      endcase
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No task enabled: no schedule before start, none ready after it; odd codes do nothing.
    write_enable_mask('0);
    send_op(make_op(pbts_pkg::FUNC_TICK, '0));
    send_op(make_op(pbts_pkg::FUNC_DELAY, '1));
    send_op(make_op(pbts_pkg::FUNC_UNLOCK, '1));
    send_op(make_op(pbts_pkg::FUNC_LOCK, '0));
    send_op(make_op(pbts_pkg::FUNC_UNLOCK, '0));
    send_op(make_op(FUNC_UNUSED_LO, 32'h5555_5555));
    send_op(make_op(FUNC_UNUSED_HI, 32'hAAAA_AAAA));
    send_op(make_op(pbts_pkg::FUNC_START, '0));
    send_op(make_op(pbts_pkg::FUNC_DELAY, '0));
    send_op(make_op(pbts_pkg::FUNC_TICK, '0));

    // All tasks enabled: switches, a schedule blocked by the lock, restart.
    write_enable_mask('1);
    send_op(make_op(pbts_pkg::FUNC_START, '0));
    send_op(make_op(pbts_pkg::FUNC_DELAY, 32'd1));
    send_op(make_op(pbts_pkg::FUNC_TICK, '0));
    send_op(make_op(pbts_pkg::FUNC_LOCK, '0));
    send_op(make_op(pbts_pkg::FUNC_DELAY, 32'd2));
    send_op(make_op(pbts_pkg::FUNC_TICK, '1));
    send_op(make_op(pbts_pkg::FUNC_UNLOCK, '0));
    send_op(make_op(3'(FUNC_UNUSED_LO + 3'd1), '1));
    send_op(make_op(pbts_pkg::FUNC_START, '0));
    send_op(make_op(pbts_pkg::FUNC_DELAY, '0));
    send_op(make_op(pbts_pkg::FUNC_TICK, '0));

    // Drive the lock depth into saturation and back down to zero, with extra unlocks at zero.
    repeat (260) send_op(make_op(pbts_pkg::FUNC_LOCK, $urandom));
    repeat (258) send_op(make_op(pbts_pkg::FUNC_UNLOCK, $urandom));
    run_random(RANDOM_PER_MASK);

    write_enable_mask(32'h0000_0001);
    run_random(RANDOM_PER_MASK);
    write_enable_mask(32'h8000_0000);
    run_random(RANDOM_PER_MASK);
    write_enable_mask($urandom);
    run_random(RANDOM_PER_MASK);
    write_enable_mask($urandom & $urandom);
    run_random(RANDOM_PER_MASK);
    write_enable_mask($urandom | $urandom);
    run_random(RANDOM_PER_MASK);

    drain();
    if (tracker.expected_results.size() != 0) begin
      tracker.errors++;
      $display("%0t: %0d expected results never arrived", $time,
               tracker.expected_results.size());
    end
    $display("Ran %0d operations under %0d enable masks: %0d ticks, %0d delays, %0d locks,",
             ops_sent, masks_written, tracker.op_count[pbts_pkg::FUNC_TICK],
             tracker.op_count[pbts_pkg::FUNC_DELAY], tracker.op_count[pbts_pkg::FUNC_LOCK]);
    $display("%0d unlocks, %0d starts; %0d switches, %0d blocked, %0d idle, %0d saturated.",
             tracker.op_count[pbts_pkg::FUNC_UNLOCK], tracker.op_count[pbts_pkg::FUNC_START],
             tracker.n_switch, tracker.n_blocked, tracker.n_none, tracker.n_saturated);
    if (tracker.errors == 0) begin
      $display("** priority_bitmap_task_scheduler: PASSED **");
    end else begin
      $display("** priority_bitmap_task_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
